/* rtl/bitmap_block_allocator_assert.svh */
// Assertion helpers for the block allocator.
// Each use is a single concurrent assertion clocked on the rising edge,
// disabled while reset is asserted.
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bba_pkg.sv */
`timescale 1ns / 1ps

package bba_pkg;

    localparam int unsigned CNT_W           = 17;   // block counts, free count
    localparam int unsigned IDX_W           = 16;   // block index on the bus
    localparam int unsigned CMD_W           = 3;
    localparam int unsigned STAT_W          = 2;
    localparam int unsigned REG_IDX_W       = 1;
    localparam int unsigned S_TDATA_W       = 24;
    localparam int unsigned M_TDATA_W       = 40;
    localparam int unsigned CNT_MAX         = (1 << CNT_W) - 1;
    localparam int unsigned BLOCK_COUNT_RST = 65536;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_RESERVED    = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 3'd0,
        CMD_FREE   = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_READ   = 3'd3,
        CMD_FORMAT = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [6:0] {
        S_FILL     = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_BIT_RD   = 7'b0000100,
        S_BIT_MOD  = 7'b0001000,
        S_SCAN_RD  = 7'b0010000,
        S_SCAN_CHK = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

endpackage

/* rtl/bitmap_block_allocator.sv */
`timescale 1ns / 1ps
// Channel   Dir  Width  Contents (lowest bit first)
// s_axis    in   24     command[2:0], block_index[18:3], bit_value[19], zero pad
// m_axis    out  40     status[1:0], result_index[17:2], read_value[18],
//                       free_blocks[35:19], zero pad
// i_cfg_*   in   1+17   register write: 0 block_count, 1 reserved_blocks
//
// Steps: free / write read the map word, then write it back; read only reads it;
//   allocate reads, then checks, one map word at a time up to the block limit;
//   format rewrites every map word. Result loads as tready returns.
// Reset: a clearing pass over all MAP_WORDS map words (2048 by default) zeroes the map;
//   s_axis_tready stays low meanwhile, config writes are still taken.
// Stalls: a new transaction is taken while the last result waits; its result then
//   holds in the done state until the output register frees up.

`include "bitmap_block_allocator_assert.svh"

module bitmap_block_allocator #(
    parameter int unsigned MAX_BLOCKS    = 65536,
    parameter int unsigned MAP_WORD_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [bba_pkg::REG_IDX_W-1:0]    i_cfg_addr,
    input  logic [bba_pkg::CNT_W-1:0]        i_cfg_wdata,
    // command stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bba_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // command, block_index, bit_value
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bba_pkg::M_TDATA_W-1:0]    m_axis_tdata   // status, result_index,
                                                            // read_value, free_blocks
);

    localparam int unsigned CW        = bba_pkg::CNT_W;
    localparam int unsigned IW        = bba_pkg::IDX_W;
    localparam int unsigned WB        = MAP_WORD_BITS;
    localparam int unsigned MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned BW        = $clog2(MAP_WORD_BITS);  // word size: power of two
    localparam int unsigned XW        = (AW + BW > CW) ? AW + BW : CW;
    localparam int unsigned MAX_CLIP  = (MAX_BLOCKS > bba_pkg::CNT_MAX) ?
                                        bba_pkg::CNT_MAX : MAX_BLOCKS;
    localparam int unsigned FREE_RST  = (MAX_BLOCKS < bba_pkg::BLOCK_COUNT_RST) ?
                                        MAX_BLOCKS : bba_pkg::BLOCK_COUNT_RST;
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_CLIP);
    localparam logic [CW-1:0] WB_CNT    = CW'(MAP_WORD_BITS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

    // sequencer and command registers
    bba_pkg::t_state  r_state, n_state;
    bba_pkg::t_cmd    r_cmd, n_cmd;
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_val, n_val;
    logic [AW-1:0]    r_addr, n_addr;      // word pointer for fill and scan
    logic [CW-1:0]    r_left, n_left;      // reserved bits still to set in fill
    logic             r_fmt, n_fmt;        // fill pass answers a format command
    logic [CW-1:0]    r_free_count, n_free_count;
    logic [CW-1:0]    r_block_count, n_block_count;
    logic [CW-1:0]    r_reserved, n_reserved;

    // pending result
    bba_pkg::t_status r_res_status, n_res_status;
    logic [IW-1:0]    r_res_idx, n_res_idx;
    logic             r_res_rd, n_res_rd;

    // output register
    logic             r_out_valid, n_out_valid;
    bba_pkg::t_status r_out_status;
    logic [IW-1:0]    r_out_idx;
    logic             r_out_rd;
    logic [CW-1:0]    r_out_free;
    logic             w_out_load;

    // map RAM
    logic [WB-1:0]    r_map [MAP_WORDS];
    logic [WB-1:0]    r_rd_data;
    logic             w_mem_re;
    logic [AW-1:0]    w_mem_raddr;
    logic             w_mem_we;
    logic [AW-1:0]    w_mem_waddr;
    logic [WB-1:0]    w_mem_wdata;

    // datapath
    logic [CW-1:0]    w_eff;
    logic [CW-1:0]    w_res_clip;
    bba_pkg::t_cmd    w_in_cmd;
    logic [IW-1:0]    w_in_idx;
    logic             w_in_val;
    logic             w_in_range;
    logic [XW-1:0]    w_idx_x;
    logic [AW-1:0]    w_idx_addr;
    logic [BW-1:0]    w_idx_bit;
    logic [WB-1:0]    w_bit_mask;
    logic             w_full;
    logic [WB-1:0]    w_onehot;
    logic [BW-1:0]    w_hit_bit;
    logic [XW-1:0]    w_found_x;
    logic [XW-1:0]    w_base_x;
    logic [XW-1:0]    w_eff_x;
    logic             w_alloc_ok;
    logic [WB-1:0]    w_fill_mask;

    assign w_eff      = (r_block_count > MAX_CNT) ? MAX_CNT : r_block_count;
    assign w_res_clip = (r_reserved > w_eff) ? w_eff : r_reserved;

    assign w_in_cmd   = bba_pkg::t_cmd'(s_axis_tdata[2:0]);
    assign w_in_idx   = s_axis_tdata[18:3];
    assign w_in_val   = s_axis_tdata[19];
    assign w_in_range = ({1'b0, w_in_idx} < w_eff);

    // word address and bit position of the latched index
    assign w_idx_x    = XW'(r_idx);
    assign w_idx_addr = w_idx_x[BW +: AW];
    assign w_idx_bit  = w_idx_x[BW-1:0];
    assign w_bit_mask = WB'(1) << w_idx_bit;

    // lowest clear bit of the word just read: isolate, then encode
    assign w_full   = &r_rd_data;
    assign w_onehot = ~r_rd_data & (r_rd_data + WB'(1));

    always_comb begin
        w_hit_bit = '0;
        for (int j = 0; j < WB; j++) begin
            if (w_onehot[j]) begin
                w_hit_bit = w_hit_bit | BW'(j);
            end
        end
    end

    assign w_found_x  = XW'({r_addr, w_hit_bit});
    assign w_base_x   = XW'({r_addr, {BW{1'b0}}});
    assign w_eff_x    = XW'(w_eff);
    assign w_alloc_ok = (r_state == bba_pkg::S_SCAN_CHK) && !w_full && (w_found_x < w_eff_x);

    // thermometer mask of the reserved bits that fall into the current word
    always_comb begin
        for (int j = 0; j < WB; j++) begin
            w_fill_mask[j] = (CW'(j) < r_left);
        end
    end

    assign w_out_load = (r_state == bba_pkg::S_DONE) && (!r_out_valid || m_axis_tready);

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_idx         = r_idx;
        n_val         = r_val;
        n_addr        = r_addr;
        n_left        = r_left;
        n_fmt         = r_fmt;
        n_free_count  = r_free_count;
        n_block_count = r_block_count;
        n_reserved    = r_reserved;
        n_res_status  = r_res_status;
        n_res_idx     = r_res_idx;
        n_res_rd      = r_res_rd;
        n_out_valid   = r_out_valid;
        w_mem_re      = 1'b0;
        w_mem_raddr   = r_addr;
        w_mem_we      = 1'b0;
        w_mem_waddr   = r_addr;
        w_mem_wdata   = '0;

        if (i_cfg_we) begin
            case (i_cfg_addr)
                bba_pkg::REG_BLOCK_COUNT: n_block_count = i_cfg_wdata;
                bba_pkg::REG_RESERVED:    n_reserved    = i_cfg_wdata;
                default: ;
            endcase
        end

        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bba_pkg::S_FILL: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = w_fill_mask;
                n_left      = (r_left >= WB_CNT) ? r_left - WB_CNT : '0;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = r_fmt ? bba_pkg::S_DONE : bba_pkg::S_IDLE;
                end else begin
                    n_addr  = r_addr + AW'(1);
                end
            end
            bba_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd        = w_in_cmd;
                    n_idx        = w_in_idx;
                    n_val        = w_in_val;
                    n_addr       = '0;
                    n_res_status = bba_pkg::ST_OK;
                    n_res_idx    = w_in_idx;
                    n_res_rd     = 1'b0;
                    case (w_in_cmd)
                        bba_pkg::CMD_ALLOC: begin
                            n_res_idx = '0;
                            if (r_free_count == '0) begin
                                n_res_status = bba_pkg::ST_NO_FREE;
                                n_state      = bba_pkg::S_DONE;
                            end else begin
                                n_state      = bba_pkg::S_SCAN_RD;
                            end
                        end
                        bba_pkg::CMD_FREE, bba_pkg::CMD_WRITE, bba_pkg::CMD_READ: begin
                            if (!w_in_range) begin
                                n_res_status = bba_pkg::ST_RANGE;
                                n_state      = bba_pkg::S_DONE;
                            end else begin
                                n_state      = bba_pkg::S_BIT_RD;
                            end
                        end
                        bba_pkg::CMD_FORMAT: begin
                            n_left       = w_res_clip;
                            n_free_count = w_eff - w_res_clip;
                            n_fmt        = 1'b1;
                            n_state      = bba_pkg::S_FILL;
                        end
                        default: begin
                            n_state = bba_pkg::S_DONE;   // unused codes do nothing
                        end
                    endcase
                end
            end
            bba_pkg::S_BIT_RD: begin
                w_mem_re    = 1'b1;
                w_mem_raddr = w_idx_addr;
                n_state     = bba_pkg::S_BIT_MOD;
            end
            bba_pkg::S_BIT_MOD: begin
                w_mem_waddr = w_idx_addr;
                case (r_cmd)
                    bba_pkg::CMD_FREE: begin
                        w_mem_we    = 1'b1;
                        w_mem_wdata = r_rd_data & ~w_bit_mask;
                        if (r_free_count < w_eff) begin
                            n_free_count = r_free_count + CW'(1);
                        end
                    end
                    bba_pkg::CMD_WRITE: begin
                        w_mem_we    = 1'b1;
                        w_mem_wdata = r_val ? (r_rd_data | w_bit_mask)
                                            : (r_rd_data & ~w_bit_mask);
                    end
                    bba_pkg::CMD_READ: begin
                        n_res_rd = |(r_rd_data & w_bit_mask);
                    end
                    default: ;
                endcase
                n_state = bba_pkg::S_DONE;
            end
            bba_pkg::S_SCAN_RD: begin
                // words at or past the block limit cannot yield a valid block
                if (w_base_x >= w_eff_x) begin
                    n_res_status = bba_pkg::ST_NO_FREE;
                    n_state      = bba_pkg::S_DONE;
                end else begin
                    w_mem_re     = 1'b1;
                    n_state      = bba_pkg::S_SCAN_CHK;
                end
            end
            bba_pkg::S_SCAN_CHK: begin
                if (!w_full) begin
                    if (w_alloc_ok) begin
                        w_mem_we     = 1'b1;
                        w_mem_wdata  = r_rd_data | w_onehot;
                        n_free_count = r_free_count - CW'(1);
                        n_res_idx    = w_found_x[IW-1:0];
                    end else begin
                        n_res_status = bba_pkg::ST_NO_FREE;
                    end
                    n_state = bba_pkg::S_DONE;
                end else if (r_addr == LAST_ADDR) begin
                    n_res_status = bba_pkg::ST_NO_FREE;
                    n_state      = bba_pkg::S_DONE;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = bba_pkg::S_SCAN_RD;
                end
            end
            bba_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_fmt   = 1'b0;
                    n_state = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bba_pkg::S_FILL;   // clearing pass after reset
            r_addr        <= '0;
            r_left        <= '0;
            r_fmt         <= 1'b0;
            r_free_count  <= CW'(FREE_RST);
            r_block_count <= CW'(bba_pkg::BLOCK_COUNT_RST);
            r_reserved    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_addr        <= n_addr;
            r_left        <= n_left;
            r_fmt         <= n_fmt;
            r_free_count  <= n_free_count;
            r_block_count <= n_block_count;
            r_reserved    <= n_reserved;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_val        <= n_val;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_rd     <= n_res_rd;
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx;
            r_out_rd     <= r_res_rd;
            r_out_free   <= r_free_count;
        end
    end

    // map RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_map[w_mem_waddr] <= w_mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r_rd_data <= r_map[w_mem_raddr];
        end
    end

    assign s_axis_tready = (r_state == bba_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_free, r_out_rd, r_out_idx, r_out_status};

    // a taken command always leaves idle
    `BBA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready still high after accept")
    // a successful allocation takes exactly one block off the count
    `BBA_ASSERT_NXT(a_alloc_dec, i_clk, i_rst_n, w_alloc_ok, r_free_count == $past(r_free_count) - CW'(1), "free count not decremented on allocate")
    // results appear only out of the done state
    `BBA_ASSERT_IMP(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == bba_pkg::S_DONE, "result without finished command")

endmodule
